@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lpss: check failed");

// prop must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
  `ASSERT_AT(lbl, clk, rst_n, !(prop))

`endif

@@ hw/rtl/lpss_pkg.sv @@
package lpss_pkg;

  localparam int unsigned STEP_COUNT_DEF = 20;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned LED_W   = 7;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned IDX_IN_W = 5;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned DIV_W   = 8;
  localparam int unsigned OFS_W   = 12;
  localparam int unsigned PULSE_W = 13;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [DIV_W-1:0] TICK_DIV_RST  = 8'd10;
  localparam logic [OFS_W-1:0] SERVO_OFS_RST = 12'd1300;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SET    = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_PLAY   = 3'd3,
    CMD_STOP   = 3'd4,
    CMD_BUTTON = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_TICK,
    OP_SET,
    OP_WRITE,
    OP_PLAY,
    OP_STOP
  } op_e;

  typedef enum logic {
    REG_TICK_DIV  = 1'b0,
    REG_SERVO_OFS = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CUR,
    SEQ_NXT
  } seq_state_e;

  typedef struct packed {
    op_e                 op;
    logic [LED_W-1:0]    led;
    logic [POS_W-1:0]    servo_a;
    logic [POS_W-1:0]    servo_b;
    logic [IDX_IN_W-1:0] idx;
    logic [WORD_W-1:0]   word;
    logic [CNT_W-1:0]    count;
  } q_entry_t;

  typedef struct packed {
    logic [DIV_W-1:0] tick_div;
    logic [OFS_W-1:0] servo_ofs;
  } cfg_t;

  typedef struct packed {
    logic                done;
    logic [LED_W-1:0]    led;
    logic [PULSE_W-1:0]  pulse_a;
    logic [PULSE_W-1:0]  pulse_b;
    logic                playing;
    logic [IDX_IN_W-1:0] step;
    logic [CNT_W-1:0]    repeats;
  } result_t;

endpackage

@@ hw/rtl/lpss_front.sv @@
module lpss_front
  import lpss_pkg::*;
#(
  parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [LED_W-1:0]    led_value_i,
  input  logic [POS_W-1:0]    servo_a_value_i,
  input  logic [POS_W-1:0]    servo_b_value_i,
  input  logic [IDX_IN_W-1:0] step_index_i,
  input  logic [WORD_W-1:0]   step_word_i,
  input  logic [CNT_W-1:0]    repeat_count_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output q_entry_t            q_entry_o
);

  assign busy     = q_full_i;
  assign q_push_o = start && !q_full_i;

  always_comb begin
    q_entry_o.op      = OP_NOP;
    q_entry_o.led     = led_value_i;
    q_entry_o.servo_a = servo_a_value_i;
    q_entry_o.servo_b = servo_b_value_i;
    q_entry_o.idx     = step_index_i;
    q_entry_o.word    = step_word_i;
    q_entry_o.count   = repeat_count_i;
    case (command_i)
      CMD_TICK: begin
        q_entry_o.op = OP_TICK;
      end
      CMD_SET: begin
        q_entry_o.op = OP_SET;
      end
      CMD_WRITE: begin
        // drop writes beyond the store
        if (32'(step_index_i) < STEP_COUNT) begin
          q_entry_o.op = OP_WRITE;
        end
      end
      CMD_PLAY: begin
        q_entry_o.op = OP_PLAY;
        if (repeat_count_i == '0) begin
          q_entry_o.count = CNT_W'(1);
        end
      end
      CMD_STOP: begin
        q_entry_o.op = OP_STOP;
      end
      CMD_BUTTON: begin
        q_entry_o.op    = OP_PLAY;
        q_entry_o.count = CNT_W'(1);
      end
      default: begin
        q_entry_o.op = OP_NOP;
      end
    endcase
  end

endmodule

@@ hw/rtl/lpss_fifo.sv @@
module lpss_fifo
  import lpss_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_data_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                do_push, do_pop;

  assign empty_o = (fill_q == '0);
  assign full_o  = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/lpss_back.sv @@
module lpss_back
  import lpss_pkg::*;
#(
  parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  q_entry_t head_i,
  input  logic     empty_i,
  output logic     pop_o,
  output result_t  result_o
);

  localparam int unsigned IDX_W = $clog2(STEP_COUNT);
  localparam int unsigned INC_W = IDX_W + 1;

  seq_state_e state_q, state_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] reps_q, reps_d;
  logic [DIV_W-1:0] pre_q, pre_d;
  logic [LED_W-1:0] led_q, led_d;
  logic [POS_W-1:0] sa_q, sa_d;
  logic [POS_W-1:0] sb_q, sb_d;
  logic             done_q, done_d;

  logic [WORD_W-1:0]     mem_q [STEP_COUNT];
  logic [STEP_COUNT-1:0] vld_q;
  logic [WORD_W-1:0]     rd_word_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      wr_addr;
  logic                  wr_en;
  logic [WORD_W-1:0]     word;

  logic [INC_W-1:0] ptr_inc;
  logic [DIV_W-1:0] div;
  logic [DIV_W-1:0] pre_inc;

  function automatic logic [PULSE_W-1:0] pulse_of(logic [POS_W-1:0] pos,
                                                  logic [OFS_W-1:0] ofs);
    logic [PULSE_W-1:0] p;
    p = '0;
    if (pos != '0) begin
      p = PULSE_W'(ofs) + PULSE_W'(pos);
    end
    return p;
  endfunction

  assign word    = rd_vld_q ? rd_word_q : '0;
  assign ptr_inc = INC_W'(ptr_q) + INC_W'(1);
  assign div     = (cfg_i.tick_div == '0) ? DIV_W'(1) : cfg_i.tick_div;
  assign pre_inc = pre_q + DIV_W'(1);
  assign wr_addr = IDX_W'(head_i.idx);

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    reps_d  = reps_q;
    pre_d   = pre_q;
    led_d   = led_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    done_d  = 1'b0;
    pop_o   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = ptr_q;
    case (state_q)
      SEQ_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          done_d = 1'b1;
          case (head_i.op)
            OP_TICK: begin
              if (pre_inc >= div) begin
                pre_d = '0;
                if (reps_q != '0) begin
                  done_d  = 1'b0;
                  state_d = SEQ_CUR;
                end
              end else begin
                pre_d = pre_inc;
              end
            end
            OP_SET: begin
              reps_d = '0;
              ptr_d  = '0;
              led_d  = head_i.led;
              sa_d   = head_i.servo_a;
              sb_d   = head_i.servo_b;
            end
            OP_WRITE: begin
              wr_en = 1'b1;
            end
            OP_PLAY: begin
              if (reps_q == '0) begin
                reps_d = head_i.count;
              end
            end
            OP_STOP: begin
              reps_d = '0;
              ptr_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_CUR: begin
        led_d = word[LED_W-1:0];
        sa_d  = word[WORD_W-1:WORD_W-POS_W];
        if (ptr_inc >= INC_W'(STEP_COUNT)) begin
          reps_d  = reps_q - CNT_W'(1);
          ptr_d   = '0;
          done_d  = 1'b1;
          state_d = SEQ_IDLE;
        end else begin
          ptr_d   = ptr_inc[IDX_W-1:0];
          rd_addr = ptr_inc[IDX_W-1:0];
          state_d = SEQ_NXT;
        end
      end
      SEQ_NXT: begin
        // end the run at a zero word
        if (word == '0) begin
          reps_d = reps_q - CNT_W'(1);
          ptr_d  = '0;
        end
        done_d  = 1'b1;
        state_d = SEQ_IDLE;
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      ptr_q   <= '0;
      reps_q  <= '0;
      pre_q   <= '0;
      led_q   <= '0;
      sa_q    <= '0;
      sb_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      reps_q  <= reps_d;
      pre_q   <= pre_d;
      led_q   <= led_d;
      sa_q    <= sa_d;
      sb_q    <= sb_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= head_i.word;
    end
    rd_word_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  assign result_o.done    = done_q;
  assign result_o.led     = led_q;
  assign result_o.pulse_a = pulse_of(sa_q, cfg_i.servo_ofs);
  assign result_o.pulse_b = pulse_of(sb_q, cfg_i.servo_ofs);
  assign result_o.playing = (reps_q != '0);
  assign result_o.step    = IDX_IN_W'(ptr_q);
  assign result_o.repeats = reps_q;

endmodule

@@ hw/rtl/led_servo_pattern_sequencer.sv @@
// Channel   Direction  Handshake               Payload
// command   in         start high, busy low    command_i and its operand fields
// result    out        done_o strobe, 1 cycle  led_out_o .. repeats_left_o
// config    in         APB write, pready high  tick_divider, servo_offset_us
//
// Commands pass through the queue; each result is registered before done_o rises.
// Tick, set, write, play, stop and button are handled in the idle state; a tick that
// runs a step then visits SEQ_CUR and, unless the step is the last entry, SEQ_NXT.
// busy is high while the two-entry command queue is full; results cannot be stalled.
// Reset clears playback, outputs, the step store valid bits and the queue, and loads
// tick_divider 10 and servo_offset_us 1300.
module led_servo_pattern_sequencer
  import lpss_pkg::*;
#(
  parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [LED_W-1:0]    led_value_i,
  input  logic [POS_W-1:0]    servo_a_value_i,
  input  logic [POS_W-1:0]    servo_b_value_i,
  input  logic [IDX_IN_W-1:0] step_index_i,
  input  logic [WORD_W-1:0]   step_word_i,
  input  logic [CNT_W-1:0]    repeat_count_i,
  output logic                done_o,
  output logic [LED_W-1:0]    led_out_o,
  output logic [PULSE_W-1:0]  servo_a_pulse_o,
  output logic [PULSE_W-1:0]  servo_b_pulse_o,
  output logic                playing_o,
  output logic [IDX_IN_W-1:0] step_now_o,
  output logic [CNT_W-1:0]    repeats_left_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t     cfg_q;
  logic     q_push, q_pop, q_full, q_empty;
  q_entry_t q_in, q_head;
  result_t  res;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_div  <= TICK_DIV_RST;
      cfg_q.servo_ofs <= SERVO_OFS_RST;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_TICK_DIV:  cfg_q.tick_div  <= pwdata[DIV_W-1:0];
        REG_SERVO_OFS: cfg_q.servo_ofs <= pwdata[OFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_TICK_DIV:  prdata = DATA_W'(cfg_q.tick_div);
      REG_SERVO_OFS: prdata = DATA_W'(cfg_q.servo_ofs);
      default:       prdata = '0;
    endcase
  end

  lpss_front #(
    .STEP_COUNT(STEP_COUNT)
  ) u_front (
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .led_value_i    (led_value_i),
    .servo_a_value_i(servo_a_value_i),
    .servo_b_value_i(servo_b_value_i),
    .step_index_i   (step_index_i),
    .step_word_i    (step_word_i),
    .repeat_count_i (repeat_count_i),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_entry_o      (q_in)
  );

  lpss_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_in),
    .pop_i      (q_pop),
    .head_o     (q_head),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  lpss_back #(
    .STEP_COUNT(STEP_COUNT)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (q_head),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .result_o(res)
  );

  assign done_o          = res.done;
  assign led_out_o       = res.led;
  assign servo_a_pulse_o = res.pulse_a;
  assign servo_b_pulse_o = res.pulse_b;
  assign playing_o       = res.playing;
  assign step_now_o      = res.step;
  assign repeats_left_o  = res.repeats;

endmodule

@@ hw/rtl/lpss_checker.sv @@
`include "assert_macros.svh"

module lpss_checker
  import lpss_pkg::*;
#(
  parameter int unsigned STEP_COUNT = STEP_COUNT_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_i,
  input logic                done_i,
  input logic                playing_i,
  input logic [IDX_IN_W-1:0] step_now_i,
  input logic [CNT_W-1:0]    repeats_left_i,
  input logic                pready_i
);

  logic [2:0] pend_q, pend_d;
  logic       acc;

  assign acc = start_i && !busy_i;

  always_comb begin
    pend_d = pend_q + 3'(acc) - 3'(done_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `ASSERT_AT(a_playing_flag, clk_i, rst_ni, done_i |-> (playing_i == (repeats_left_i != '0)))
  `ASSERT_AT(a_step_range, clk_i, rst_ni, done_i |-> (32'(step_now_i) < STEP_COUNT))
  `ASSERT_NEVER(a_no_stray_result, clk_i, rst_ni, done_i && (pend_q == '0))
  `ASSERT_AT(a_pending_bound, clk_i, rst_ni, pend_q <= 3'd3)
  `ASSERT_AT(a_pready_high, clk_i, rst_ni, pready_i)

endmodule

bind led_servo_pattern_sequencer lpss_checker #(
  .STEP_COUNT(STEP_COUNT)
) u_lpss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start),
  .busy_i        (busy),
  .done_i        (done_o),
  .playing_i     (playing_o),
  .step_now_i    (step_now_o),
  .repeats_left_i(repeats_left_o),
  .pready_i      (pready)
);

@@ tb/led_servo_pattern_sequencer_tb.sv @@
module led_servo_pattern_sequencer_tb;
  import lpss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS = STEP_COUNT_DEF;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int unsigned PHASES = 6;
  localparam logic [DATA_W-1:0] DIV_SETTING [PHASES] =
    '{32'h0000_0001, 32'hFFFF_FF00, 32'h0000_0007, 32'h0000_0002, 32'h0000_00FF, 32'h0000_0001};
  localparam logic [DATA_W-1:0] OFS_SETTING [PHASES] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0800, 32'h0000_0A5C, 32'h0000_0001, 32'h0000_0514};
  localparam int unsigned PHASE_ITEMS [PHASES] = '{150, 100, 100, 100, 40, 110};

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [LED_W-1:0]    led;
    logic [POS_W-1:0]    pos_a;
    logic [POS_W-1:0]    pos_b;
    logic [IDX_IN_W-1:0] idx;
    logic [WORD_W-1:0]   word;
    logic [CNT_W-1:0]    count;
  } cmd_item_t;

  typedef struct packed {
    logic [LED_W-1:0]    led;
    logic [PULSE_W-1:0]  pulse_a;
    logic [PULSE_W-1:0]  pulse_b;
    logic                playing;
    logic [IDX_IN_W-1:0] step;
    logic [CNT_W-1:0]    reps;
  } out_t;

  typedef struct {
    cmd_item_t   cmd;
    int unsigned times;
    bit          typed;
    out_t        want;
  } script_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command_i = '0;
  logic [LED_W-1:0]    led_value_i = '0;
  logic [POS_W-1:0]    servo_a_value_i = '0;
  logic [POS_W-1:0]    servo_b_value_i = '0;
  logic [IDX_IN_W-1:0] step_index_i = '0;
  logic [WORD_W-1:0]   step_word_i = '0;
  logic [CNT_W-1:0]    repeat_count_i = '0;
  logic                done_o;
  logic [LED_W-1:0]    led_out_o;
  logic [PULSE_W-1:0]  servo_a_pulse_o;
  logic [PULSE_W-1:0]  servo_b_pulse_o;
  logic                playing_o;
  logic [IDX_IN_W-1:0] step_now_o;
  logic [CNT_W-1:0]    repeats_left_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  logic [WORD_W-1:0] steps_mem [STEPS];
  int unsigned       seq_ptr = 0;
  logic [CNT_W-1:0]  plays_left = '0;
  logic [DIV_W-1:0]  tick_count = '0;
  logic [LED_W-1:0]  led_now = '0;
  logic [POS_W-1:0]  pos_a_now = '0;
  logic [POS_W-1:0]  pos_b_now = '0;
  logic [DIV_W-1:0]  div_now = TICK_DIV_RST;
  logic [OFS_W-1:0]  ofs_now = SERVO_OFS_RST;

  out_t        pending_outputs[$];
  script_row_t script[$];
  int unsigned failures = 0;
  int unsigned cycles = 0;
  int unsigned steady_left = 0;

  led_servo_pattern_sequencer i_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .command_i,
    .led_value_i,
    .servo_a_value_i,
    .servo_b_value_i,
    .step_index_i,
    .step_word_i,
    .repeat_count_i,
    .done_o,
    .led_out_o,
    .servo_a_pulse_o,
    .servo_b_pulse_o,
    .playing_o,
    .step_now_o,
    .repeats_left_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [PULSE_W-1:0] pulse_for(logic [POS_W-1:0] pos);
    if (pos == '0) return '0;
    return PULSE_W'({1'b0, ofs_now}) + PULSE_W'(pos);
  endfunction

  function automatic void run_step();
    logic [WORD_W-1:0] w;
    if (seq_ptr >= STEPS) seq_ptr = 0;
    if (plays_left == '0) return;
    w = steps_mem[seq_ptr];
    led_now = w[LED_W-1:0];
    pos_a_now = w[15:8];
    seq_ptr++;
    if (seq_ptr >= STEPS || steps_mem[seq_ptr] == '0) begin
      plays_left--;
      seq_ptr = 0;
    end
  endfunction

  function automatic out_t advance_player(cmd_item_t c);
    logic [DIV_W-1:0] div;
    out_t o;
    case (c.command)
      CMD_TICK: begin
        div = (div_now == '0) ? DIV_W'(1) : div_now;
        tick_count = tick_count + 1'b1;
        if (tick_count >= div) begin
          tick_count = '0;
          run_step();
        end
      end
      CMD_SET: begin
        plays_left = '0;
        seq_ptr = 0;
        led_now = c.led;
        pos_a_now = c.pos_a;
        pos_b_now = c.pos_b;
      end
      CMD_WRITE: begin
        if (c.idx < STEPS) steps_mem[c.idx] = c.word;
      end
      CMD_PLAY: begin
        if (plays_left == '0) plays_left = (c.count == '0) ? CNT_W'(1) : c.count;
      end
      CMD_STOP: begin
        plays_left = '0;
        seq_ptr = 0;
      end
      CMD_BUTTON: begin
        if (plays_left == '0) plays_left = CNT_W'(1);
      end
      default: ;
    endcase
    o.led = led_now;
    o.pulse_a = pulse_for(pos_a_now);
    o.pulse_b = pulse_for(pos_b_now);
    o.playing = (plays_left != '0);
    o.step = IDX_IN_W'(seq_ptr);
    o.reps = plays_left;
    return o;
  endfunction

  function automatic cmd_item_t make_cmd(logic [CMD_W-1:0] command, logic [LED_W-1:0] led,
                                         logic [POS_W-1:0] pos_a, logic [POS_W-1:0] pos_b,
                                         logic [IDX_IN_W-1:0] idx, logic [WORD_W-1:0] word,
                                         logic [CNT_W-1:0] count);
    cmd_item_t c;
    c.command = command;
    c.led = led;
    c.pos_a = pos_a;
    c.pos_b = pos_b;
    c.idx = idx;
    c.word = word;
    c.count = count;
    return c;
  endfunction

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    c.led = LED_W'($urandom);
    c.pos_a = POS_W'($urandom);
    c.pos_b = POS_W'($urandom);
    c.idx = ($urandom_range(0, 9) == 0) ? IDX_IN_W'($urandom_range(STEPS, 31))
                                         : IDX_IN_W'($urandom_range(0, STEPS - 1));
    c.word = ($urandom_range(0, 9) == 0) ? '0 : WORD_W'($urandom_range(1, 65535));
    sel = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0:       c.count = '0;
      1, 2:    c.count = CNT_W'($urandom);
      default: c.count = CNT_W'($urandom_range(1, 4));
    endcase
    if (sel < 47) c.command = CMD_TICK;
    else if (sel < 67) c.command = CMD_WRITE;
    else if (sel < 77) c.command = CMD_PLAY;
    else if (sel < 85) c.command = CMD_BUTTON;
    else if (sel < 90) c.command = CMD_SET;
    else if (sel < 95) c.command = CMD_STOP;
    else if (sel < 97) c.command = CMD_SPARE_LO;
    else c.command = CMD_SPARE_HI;
    return c;
  endfunction

  function automatic string show(out_t o);
    return $sformatf("led %0d a %0d b %0d playing %0b step %0d repeats %0d",
                     o.led, o.pulse_a, o.pulse_b, o.playing, o.step, o.reps);
  endfunction

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk_i) begin : result_check
    out_t got;
    out_t want;
    string diffs;
    if (rst_ni && done_o) begin
      got = '{led_out_o, servo_a_pulse_o, servo_b_pulse_o, playing_o, step_now_o,
              repeats_left_o};
      if (pending_outputs.size() == 0) begin
        note_failure($sformatf("result with no command outstanding: %s", show(got)));
      end else begin
        want = pending_outputs.pop_front();
        diffs = "";
        if (got.led != want.led) diffs = {diffs, " led_out"};
        if (got.pulse_a != want.pulse_a) diffs = {diffs, " servo_a_pulse"};
        if (got.pulse_b != want.pulse_b) diffs = {diffs, " servo_b_pulse"};
        if (got.playing != want.playing) diffs = {diffs, " playing"};
        if (got.step != want.step) diffs = {diffs, " step_now"};
        if (got.reps != want.reps) diffs = {diffs, " repeats_left"};
        if (diffs != "")
          note_failure($sformatf("mismatch on%s: expected %s, got %s", diffs, show(want),
                                 show(got)));
      end
    end
  end

  task automatic send_cmd(input cmd_item_t it, input bit typed, input out_t want);
    int unsigned gap;
    out_t predicted;
    start <= 1'b1;
    command_i <= it.command;
    led_value_i <= it.led;
    servo_a_value_i <= it.pos_a;
    servo_b_value_i <= it.pos_b;
    step_index_i <= it.idx;
    step_word_i <= it.word;
    repeat_count_i <= it.count;
    do @(posedge clk_i); while (busy);
    predicted = advance_player(it);
    pending_outputs.push_back(typed ? want : predicted);
    if (steady_left > 0) begin
      steady_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_e r, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (r == REG_TICK_DIV) div_now = value[DIV_W-1:0];
    else ofs_now = value[OFS_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_check(input reg_e r);
    logic [DATA_W-1:0] got;
    logic [DATA_W-1:0] want;
    want = (r == REG_TICK_DIV) ? DATA_W'(div_now) : DATA_W'(ofs_now);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== want)
      note_failure($sformatf("register %s read: expected %0d, got %0d", r.name(), want, got));
  endtask

  initial begin
    foreach (steps_mem[i]) steps_mem[i] = '0;

    script.push_back('{make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0), 1, 1'b1, out_t'(0)});
    script.push_back('{make_cmd(CMD_SET, 7'h7F, 8'hFF, 8'hFF, 0, 0, 0), 1, 1'b1,
                       out_t'{7'd127, 13'd1555, 13'd1555, 1'b0, 5'd0, 8'd0}});
    script.push_back('{make_cmd(CMD_SET, 0, 0, 1, 0, 0, 0), 1, 1'b1,
                       out_t'{7'd0, 13'd0, 13'd1301, 1'b0, 5'd0, 8'd0}});
    script.push_back('{make_cmd(CMD_SET, 1, 1, 0, 0, 0, 0), 1, 1'b1,
                       out_t'{7'd1, 13'd1301, 13'd0, 1'b0, 5'd0, 8'd0}});
    script.push_back('{make_cmd(CMD_WRITE, 0, 0, 0, 5'd0, 16'hFFFF, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_WRITE, 0, 0, 0, 5'd19, 16'h0101, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_WRITE, 0, 0, 0, 5'd20, 16'h1234, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_WRITE, 0, 0, 0, 5'd31, 16'hABCD, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_WRITE, 0, 0, 0, 5'd1, 16'h8055, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_PLAY, 0, 0, 0, 0, 0, 8'd0), 1, 1'b1,
                       out_t'{7'd1, 13'd1301, 13'd0, 1'b1, 5'd0, 8'd1}});
    script.push_back('{make_cmd(CMD_PLAY, 0, 0, 0, 0, 0, 8'd200), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_BUTTON, 0, 0, 0, 0, 0, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_SPARE_LO, 7'h7F, 8'hFF, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF), 1,
                       1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_SPARE_HI, 7'h7F, 8'hFF, 8'hFF, 5'h1F, 16'hFFFF, 8'hFF), 1,
                       1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0), 9, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_STOP, 0, 0, 0, 0, 0, 0), 1, 1'b1,
                       out_t'{7'd127, 13'd1555, 13'd0, 1'b0, 5'd0, 8'd0}});
    script.push_back('{make_cmd(CMD_BUTTON, 0, 0, 0, 0, 0, 0), 1, 1'b0, out_t'(0)});
    script.push_back('{make_cmd(CMD_SET, 7'h2A, 8'h80, 8'h7F, 0, 0, 0), 1, 1'b1,
                       out_t'{7'd42, 13'd1428, 13'd1427, 1'b0, 5'd0, 8'd0}});
    script.push_back('{make_cmd(CMD_PLAY, 0, 0, 0, 0, 0, 8'd255), 1, 1'b0, out_t'(0)});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r])
      repeat (script[r].times) send_cmd(script[r].cmd, script[r].typed, script[r].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      cfg_write(REG_TICK_DIV, DIV_SETTING[p]);
      cfg_write(REG_SERVO_OFS, OFS_SETTING[p]);
      cfg_check(REG_TICK_DIV);
      cfg_check(REG_SERVO_OFS);
      repeat (PHASE_ITEMS[p]) send_cmd(random_cmd(), 1'b0, out_t'(0));
      drain();
    end

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lpss_pkg.sv
hw/rtl/lpss_front.sv
hw/rtl/lpss_fifo.sv
hw/rtl/lpss_back.sv
hw/rtl/led_servo_pattern_sequencer.sv
hw/rtl/lpss_checker.sv
tb/led_servo_pattern_sequencer_tb.sv
